>>> src/bcsa_pkg.sv
// Shared types and constants for the binned chi-square accumulator.
// Used by every module under src; depends on nothing.
package bcsa_pkg;

  // Default widths; the top level may override these by parameter.
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF    = 12;

  // Fixed data widths of the arithmetic.
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned PROD_BITS  = 2 * VALUE_BITS;
  localparam int unsigned SUM_BITS   = 48;
  localparam int unsigned DEN_BITS   = PROD_BITS + 1;
  localparam int unsigned QUOT_STEPS = SUM_BITS;
  localparam int unsigned STEP_CNT_BITS = $clog2(QUOT_STEPS + 1);

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // Reset value of the bin count register.
  localparam int unsigned BIN_COUNT_RESET = 100;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BIN_COUNT    = 2'd0,
    CFG_WINDOW_FIRST = 2'd1,
    CFG_WINDOW_LAST  = 2'd2
  } cfg_reg_e;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_DIFF,
    S_SQ_EA,
    S_SQ_EB,
    S_DEN,
    S_DIV_START,
    S_DIV_RUN,
    S_ACC,
    S_EMIT
  } state_e;

  // Status reported by the divider to the sequencer.
  typedef struct packed {
    logic done;
    logic big;
  } div_stat_t;

endpackage

>>> src/binned_chi_square_accumulator.sv
// Top level of the binned chi-square accumulator: sequencer, window clamp,
// configuration registers and the running sum. Uses bcsa_pkg, bcsa_mul, bcsa_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one bin pair per request.
//   Output channel (out_valid_o / out_stall_i) gives one request holding the
//   accumulated chi-square and its overflow flag after each final bin.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//   must only be issued while the block is idle.
// Sequencing:
//   A bin inside the window occupies the block from its request to the next:
//   the accepting cycle, three squarings on the shared multiplier, the divisor,
//   the divider start, the restoring divider (48 quotient bits, one per cycle,
//   then seeing it finish) and the accumulation. A bin outside the window
//   passes only through the accepting and accumulating states. A final bin then
//   moves the sum into the output register, waiting while that register is full.
// Reset:
//   Clears the sum and its flag, the output valid flag and the sequencer, and
//   sets bin_count to 100 and both window bounds to 0.
// Stall:
//   The output register holds a result while the receiver stalls; the next
//   items are still accepted, and only a further final bin waits until the
//   register is free.
module binned_chi_square_accumulator #(
  parameter int unsigned FRACTION_BITS = bcsa_pkg::FRACTION_BITS_DEF,
  parameter int unsigned INDEX_BITS    = bcsa_pkg::INDEX_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [INDEX_BITS-1:0]                  bin_index_i,
  input  logic signed [bcsa_pkg::VALUE_BITS-1:0] value_a_i,
  input  logic [bcsa_pkg::VALUE_BITS-1:0]        error_a_i,
  input  logic signed [bcsa_pkg::VALUE_BITS-1:0] value_b_i,
  input  logic [bcsa_pkg::VALUE_BITS-1:0]        error_b_i,
  input  logic                                   final_bin_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [bcsa_pkg::SUM_BITS-1:0]          chi_square_o,
  output logic                                   overflowed_o,
  // Configuration channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bcsa_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [INDEX_BITS-1:0]                  cfg_data_i
);

  localparam int unsigned HiBits = bcsa_pkg::PROD_BITS + FRACTION_BITS - bcsa_pkg::SUM_BITS;
  localparam int unsigned VB     = bcsa_pkg::VALUE_BITS;
  localparam int unsigned SB     = bcsa_pkg::SUM_BITS;
  localparam int unsigned DB     = bcsa_pkg::DEN_BITS;
  localparam int unsigned PB     = bcsa_pkg::PROD_BITS;

  bcsa_pkg::state_e    state_q, state_d;
  bcsa_pkg::div_stat_t div_stat;

  logic [INDEX_BITS-1:0] bin_count_q;
  logic [INDEX_BITS-1:0] window_first_q;
  logic [INDEX_BITS-1:0] window_last_q;
  logic [INDEX_BITS-1:0] eff_last;
  logic [INDEX_BITS-1:0] eff_first;
  logic                  in_window;

  logic [VB:0]   diff;
  logic [VB:0]   diff_abs;
  logic [VB-1:0] mag_q;
  logic [VB-1:0] err_a_q;
  logic [VB-1:0] err_b_q;
  logic          final_q;
  logic          in_win_q;
  logic [PB-1:0] d2_q;
  logic [PB-1:0] sa_q;
  logic [DB-1:0] den_q;
  logic [DB-1:0] den_sum;

  logic          mul_en;
  logic [VB-1:0] mul_a;
  logic [VB-1:0] mul_b;
  logic [PB-1:0] product;
  logic          div_start;
  logic [SB-1:0] quot;

  logic [SB-1:0] sum_q;
  logic          sat_q;
  logic [SB-1:0] term;
  logic [SB:0]   sum_wide;

  logic          in_accept;
  logic          out_free;
  logic          out_load;
  logic          out_valid_q;
  logic [SB-1:0] out_sum_q;
  logic          out_ovf_q;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q    <= INDEX_BITS'(bcsa_pkg::BIN_COUNT_RESET);
      window_first_q <= '0;
      window_last_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bcsa_pkg::cfg_reg_e'(cfg_index_i))
        bcsa_pkg::CFG_BIN_COUNT:    bin_count_q    <= cfg_data_i;
        bcsa_pkg::CFG_WINDOW_FIRST: window_first_q <= cfg_data_i;
        bcsa_pkg::CFG_WINDOW_LAST:  window_last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window clamp: an open or oversized last bin becomes the bin count, and a
  // first bin beyond the last falls back to zero.
  always_comb begin
    eff_last  = (window_last_q == '0 || window_last_q > bin_count_q) ?
                bin_count_q : window_last_q;
    eff_first = (window_first_q > eff_last) ? '0 : window_first_q;
    in_window = (bin_index_i >= eff_first) && (bin_index_i <= eff_last);
  end

  // Magnitude of the content difference; it always fits in 32 bits.
  always_comb begin
    diff     = {value_a_i[VB-1], value_a_i} - {value_b_i[VB-1], value_b_i};
    diff_abs = diff[VB] ? (~diff + 1'b1) : diff;
  end

  assign in_stall_o = (state_q != bcsa_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: next state and the controls of the shared units.
  always_comb begin
    state_d   = state_q;
    mul_en    = 1'b0;
    mul_a     = mag_q;
    mul_b     = mag_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      bcsa_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = in_window ? bcsa_pkg::S_SQ_DIFF : bcsa_pkg::S_ACC;
        end
      end
      bcsa_pkg::S_SQ_DIFF: begin
        mul_en  = 1'b1;
        state_d = bcsa_pkg::S_SQ_EA;
      end
      bcsa_pkg::S_SQ_EA: begin
        mul_en  = 1'b1;
        mul_a   = err_a_q;
        mul_b   = err_a_q;
        state_d = bcsa_pkg::S_SQ_EB;
      end
      bcsa_pkg::S_SQ_EB: begin
        mul_en  = 1'b1;
        mul_a   = err_b_q;
        mul_b   = err_b_q;
        state_d = bcsa_pkg::S_DEN;
      end
      bcsa_pkg::S_DEN: begin
        state_d = bcsa_pkg::S_DIV_START;
      end
      bcsa_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_d   = bcsa_pkg::S_DIV_RUN;
      end
      bcsa_pkg::S_DIV_RUN: begin
        if (div_stat.done) begin
          state_d = bcsa_pkg::S_ACC;
        end
      end
      bcsa_pkg::S_ACC: begin
        state_d = final_q ? bcsa_pkg::S_EMIT : bcsa_pkg::S_IDLE;
      end
      bcsa_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = bcsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bcsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared multiplier: squared difference, then each squared error.
  bcsa_mul u_mul (
    .clk_i     (clk_i),
    .en_i      (mul_en),
    .op_a_i    (mul_a),
    .op_b_i    (mul_b),
    .product_o (product)
  );

  // Divisor is the sum of squared errors, or 1.0 when both are zero.
  always_comb begin
    den_sum = {1'b0, sa_q} + {1'b0, product};
    if (den_sum == '0) begin
      den_sum = DB'(1) << (2 * FRACTION_BITS);
    end
  end

  // Item capture and intermediate products.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q    <= diff_abs[VB-1:0];
      err_a_q  <= error_a_i;
      err_b_q  <= error_b_i;
      final_q  <= final_bin_i;
      in_win_q <= in_window;
    end
    if (state_q == bcsa_pkg::S_SQ_EA) begin
      d2_q <= product;
    end
    if (state_q == bcsa_pkg::S_SQ_EB) begin
      sa_q <= product;
    end
    if (state_q == bcsa_pkg::S_DEN) begin
      den_q <= den_sum;
    end
  end

  // Numerator is the squared difference scaled by the fraction bits.
  bcsa_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (d2_q[PB-1 -: HiBits]),
    .num_lo_i ({d2_q[SB-FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}}),
    .den_i    (den_q),
    .quot_o   (quot),
    .status_o (div_stat)
  );

  // Saturating accumulation of the term.
  always_comb begin
    term     = div_stat.big ? bcsa_pkg::SUM_MAX : quot;
    sum_wide = {1'b0, sum_q} + {1'b0, term};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (state_q == bcsa_pkg::S_ACC && in_win_q) begin
      if (div_stat.big || sum_wide[SB]) begin
        sum_q <= bcsa_pkg::SUM_MAX;
        sat_q <= 1'b1;
      end else begin
        sum_q <= sum_wide[SB-1:0];
      end
    end else if (out_load) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q <= sum_q;
      out_ovf_q <= sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chi_square_o = out_sum_q;
  assign overflowed_o = out_ovf_q;

  // A saturated running sum always sits at its maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> sum_q == bcsa_pkg::SUM_MAX)
    else $error("saturation flag set while sum below maximum");

  // A flagged result carries the saturated value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> chi_square_o == bcsa_pkg::SUM_MAX)
    else $error("overflowed result not at maximum");

  // An accepted request makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken twice in consecutive cycles");

  // The divider result is consumed as soon as it is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcsa_pkg::S_DIV_RUN && div_stat.done |=> state_q == bcsa_pkg::S_ACC)
    else $error("divider result not accumulated");

  // The running sum is cleared once the result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> sum_q == '0 && !sat_q && out_valid_q)
    else $error("sum not cleared after emitting a result");

endmodule

>>> src/bcsa_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on bcsa_pkg for the operand and product widths.
module bcsa_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [bcsa_pkg::VALUE_BITS-1:0]   op_a_i,
  input  logic [bcsa_pkg::VALUE_BITS-1:0]   op_b_i,
  output logic [bcsa_pkg::PROD_BITS-1:0]    product_o
);

  logic [bcsa_pkg::PROD_BITS-1:0] product_q;
  logic [bcsa_pkg::PROD_BITS-1:0] product_d;

  // Full-width product of the two operands.
  assign product_d = bcsa_pkg::PROD_BITS'(op_a_i) * bcsa_pkg::PROD_BITS'(op_b_i);

  // The product is held until the next enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      product_q <= product_d;
    end
  end

  assign product_o = product_q;

endmodule

>>> src/bcsa_div.sv
// Restoring divider giving a 48-bit quotient, one bit per cycle, with an
// overflow flag when the quotient would not fit. Depends on bcsa_pkg.
module bcsa_div #(
  parameter int unsigned FRACTION_BITS = bcsa_pkg::FRACTION_BITS_DEF
) (
  input  logic                                                         clk_i,
  input  logic                                                         rst_ni,
  input  logic                                                         start_i,
  input  logic [bcsa_pkg::PROD_BITS+FRACTION_BITS-bcsa_pkg::SUM_BITS-1:0] num_hi_i,
  input  logic [bcsa_pkg::SUM_BITS-1:0]                                num_lo_i,
  input  logic [bcsa_pkg::DEN_BITS-1:0]                                den_i,
  output logic [bcsa_pkg::SUM_BITS-1:0]                                quot_o,
  output bcsa_pkg::div_stat_t                                          status_o
);

  logic [bcsa_pkg::DEN_BITS-1:0]      rem_q;
  logic [bcsa_pkg::DEN_BITS-1:0]      rem_d;
  logic [bcsa_pkg::SUM_BITS-1:0]      quot_q;
  logic [bcsa_pkg::SUM_BITS-1:0]      quot_d;
  logic                               big_q;
  logic [bcsa_pkg::STEP_CNT_BITS-1:0] cnt_q;
  logic                               busy_q;
  logic                               done_q;
  logic [bcsa_pkg::DEN_BITS:0]        rem_sh;
  logic [bcsa_pkg::DEN_BITS:0]        rem_sub;
  logic                               step_ge;
  logic [bcsa_pkg::DEN_BITS-1:0]      num_hi_ext;

  // The upper part of the numerator seeds the remainder; when it already
  // reaches the divisor the quotient has more than 48 bits.
  assign num_hi_ext = bcsa_pkg::DEN_BITS'(num_hi_i);

  // One restoring step: shift in the next numerator bit, try to subtract.
  always_comb begin
    rem_sh  = {rem_q, quot_q[bcsa_pkg::SUM_BITS-1]};
    rem_sub = rem_sh - {1'b0, den_i};
    step_ge = (rem_sh >= {1'b0, den_i});
    rem_d   = step_ge ? rem_sub[bcsa_pkg::DEN_BITS-1:0] : rem_sh[bcsa_pkg::DEN_BITS-1:0];
    quot_d  = {quot_q[bcsa_pkg::SUM_BITS-2:0], step_ge};
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= bcsa_pkg::STEP_CNT_BITS'(bcsa_pkg::QUOT_STEPS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == bcsa_pkg::STEP_CNT_BITS'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Remainder and quotient shift register; the quotient register first
  // carries the low numerator bits, which are shifted out as quotient
  // bits come in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_hi_ext;
      quot_q <= num_lo_i;
      big_q  <= (num_hi_ext >= den_i);
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o        = quot_q;
  assign status_o.done = done_q;
  assign status_o.big  = big_q;

  // A started division is never reported done in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_q && busy_q)
    else $error("divider reported done right after a start");

  // Busy and done are never set together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done at once");

  // A busy divider at its last step, with no new start, then reports done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == bcsa_pkg::STEP_CNT_BITS'(1) && !start_i |=> done_q)
    else $error("divider did not finish after its last step");

endmodule

>>> sim/binned_chi_square_accumulator_tb.sv
// Self-checking testbench for the binned chi-square accumulator.
// Predicts every emitted sum from the bin requests it sends and compares it
// field by field; depends on bcsa_pkg and the top level under src.
`timescale 1ns / 1ps

module binned_chi_square_accumulator_tb;

  localparam int unsigned FRAC_W       = bcsa_pkg::FRACTION_BITS_DEF;
  localparam int unsigned IDX_W        = bcsa_pkg::INDEX_BITS_DEF;
  localparam int unsigned VAL_W        = bcsa_pkg::VALUE_BITS;
  localparam int unsigned SUM_W        = bcsa_pkg::SUM_BITS;
  // Drain time: long enough for a bin inside the window and a final bin's emit step.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RANDOM_BINS  = 730;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] va;
    logic [VAL_W-1:0]        ea;
    logic signed [VAL_W-1:0] vb;
    logic [VAL_W-1:0]        eb;
    logic                    fin;
  } bin_req_t;

  typedef struct {
    logic [SUM_W-1:0] chi;
    logic             ovf;
  } chi_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [IDX_W-1:0]        bin_index_i = '0;
  logic signed [VAL_W-1:0] value_a_i   = '0;
  logic [VAL_W-1:0]        error_a_i   = '0;
  logic signed [VAL_W-1:0] value_b_i   = '0;
  logic [VAL_W-1:0]        error_b_i   = '0;
  logic                    final_bin_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [SUM_W-1:0]        chi_square_o;
  logic                    overflowed_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  bcsa_pkg::cfg_reg_e      cfg_index_i = bcsa_pkg::CFG_BIN_COUNT;
  logic [IDX_W-1:0]        cfg_data_i  = '0;

  // Predicted register contents and accumulator state.
  logic [IDX_W-1:0] cfg_bin_count = IDX_W'(bcsa_pkg::BIN_COUNT_RESET);
  logic [IDX_W-1:0] cfg_first     = '0;
  logic [IDX_W-1:0] cfg_last      = '0;
  logic [SUM_W-1:0] sum_acc       = '0;
  logic             sum_sat       = 1'b0;

  chi_result_t pending_sums[$];
  int unsigned mismatch_count = 0;
  int unsigned bins_sent      = 0;
  logic        no_gaps        = 1'b0;
  int unsigned stall_hold     = 0;
  logic        stall_next     = 1'b0;

  binned_chi_square_accumulator #(
    .FRACTION_BITS(FRAC_W),
    .INDEX_BITS   (IDX_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .bin_index_i (bin_index_i),
    .value_a_i   (value_a_i),
    .error_a_i   (error_a_i),
    .value_b_i   (value_b_i),
    .error_b_i   (error_b_i),
    .final_bin_i (final_bin_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .chi_square_o(chi_square_o),
    .overflowed_o(overflowed_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Effective window after the clamp rules have been applied.
  function automatic void window_bounds(output logic [IDX_W-1:0] lo,
                                        output logic [IDX_W-1:0] hi);
    hi = cfg_last;
    if (hi == '0 || hi > cfg_bin_count) hi = cfg_bin_count;
    lo = cfg_first;
    if (lo > hi) lo = '0;
  endfunction

  // Adds the term of one bin to the predicted sum and queues the result on a
  // final bin. Returns whether the bin lay inside the window.
  function automatic logic fold_bin_into_sum(input bin_req_t b);
    logic [IDX_W-1:0]      lo, hi;
    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        mag;
    logic [127:0]          num, den, quot;
    logic                  counted;
    chi_result_t           res;
    window_bounds(lo, hi);
    counted = (b.idx >= lo) && (b.idx <= hi);
    if (counted) begin
      diff = {b.va[VAL_W-1], b.va} - {b.vb[VAL_W-1], b.vb};
      mag  = diff[VAL_W] ? -diff : diff;
      num  = (128'(mag) * 128'(mag)) << FRAC_W;
      den  = 128'(b.ea) * 128'(b.ea) + 128'(b.eb) * 128'(b.eb);
      // Both errors zero: the divisor is one in the squared fixed-point scale.
      if (den == '0) den = 128'(1) << (2 * FRAC_W);
      quot = num / den;
      if (quot > 128'(bcsa_pkg::SUM_MAX) || quot > 128'(bcsa_pkg::SUM_MAX - sum_acc)) begin
        sum_acc = bcsa_pkg::SUM_MAX;
        sum_sat = 1'b1;
      end else begin
        sum_acc = sum_acc + quot[SUM_W-1:0];
      end
    end
    if (b.fin) begin
      res.chi = sum_acc;
      res.ovf = sum_sat;
      pending_sums.insert(pending_sums.size(), res);
      sum_acc = '0;
      sum_sat = 1'b0;
    end
    return counted;
  endfunction

  function automatic bin_req_t mk_bin(input logic [IDX_W-1:0] idx, input logic [31:0] va,
                                      input logic [31:0] ea, input logic [31:0] vb,
                                      input logic [31:0] eb, input logic fin);
    bin_req_t b;
    b.idx = idx;
    b.va  = va;
    b.ea  = ea;
    b.vb  = vb;
    b.eb  = eb;
    b.fin = fin;
    return b;
  endfunction

  // Mostly moderate contents, sometimes the full signed range.
  function automatic logic [31:0] rand_content();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(0, 32'h3FFFFF) - 32'h200000;
  endfunction

  function automatic logic [31:0] rand_error();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(32'h400, 32'h40000);
    endcase
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Sends one bin request. With no gap the valid stays high, so the caller
  // either sends the next request at once or drops the valid via idle_input.
  task automatic send_bin(input bin_req_t b);
    int unsigned gap;
    bin_index_i <= b.idx;
    value_a_i   <= b.va;
    error_a_i   <= b.ea;
    value_b_i   <= b.vb;
    error_b_i   <= b.eb;
    final_bin_i <= b.fin;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    void'(fold_bin_into_sum(b));
    bins_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_sums();
    idle_input();
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // Lets the last request finish even when it produced no result.
  task automatic settle_block();
    wait_for_sums();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input bcsa_pkg::cfg_reg_e idx, input logic [IDX_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      bcsa_pkg::CFG_BIN_COUNT:    cfg_bin_count = data;
      bcsa_pkg::CFG_WINDOW_FIRST: cfg_first     = data;
      bcsa_pkg::CFG_WINDOW_LAST:  cfg_last      = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_window(input logic [IDX_W-1:0] bc, input logic [IDX_W-1:0] first,
                              input logic [IDX_W-1:0] last);
    settle_block();
    write_register(bcsa_pkg::CFG_BIN_COUNT, bc);
    write_register(bcsa_pkg::CFG_WINDOW_FIRST, first);
    write_register(bcsa_pkg::CFG_WINDOW_LAST, last);
  endtask

  // Field extremes under the reset window (bins 0 to 100).
  task automatic test_special_bins();
    // All zero in the underflow bin, which lies inside the window.
    send_bin(mk_bin(12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    // Both errors zero with the widest difference; the second one overflows the sum.
    send_bin(mk_bin(12'd1, 32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 1'b0));
    send_bin(mk_bin(12'd100, 32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 1'b0));
    // The saturated sum stays saturated and is emitted with its flag.
    send_bin(mk_bin(12'd50, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 1'b1));
    // Outside the window: nothing is added, but the final mark still emits.
    send_bin(mk_bin(12'd101, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 1'b1));
    send_bin(mk_bin(12'd4095, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b0));
    send_bin(mk_bin(12'd50, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 1'b1));
    // Largest errors make the divisor carry past 64 bits.
    send_bin(mk_bin(12'd2, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1));
    // Tiny divisor: a single term too large for the sum.
    send_bin(mk_bin(12'd3, 32'hFFFF0000, 32'h0, 32'h00010000, 32'h00000001, 1'b1));
    // Equal negative contents give a zero term.
    send_bin(mk_bin(12'd99, 32'h80000000, 32'h00008000, 32'h80000000, 32'h00008000, 1'b1));
  endtask

  // Each clamp rule of the window, including the extreme register values.
  task automatic test_window_clamp();
    // A bin count of zero leaves the underflow bin alone in the window.
    apply_window(12'd0, 12'd0, 12'd0);
    send_bin(mk_bin(12'd0, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 1'b0));
    send_bin(mk_bin(12'd1, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 1'b1));
    // Top of the index range.
    apply_window(12'd4095, 12'd4095, 12'd4095);
    send_bin(mk_bin(12'd4094, 32'h00020000, 32'h00010000, 32'h0, 32'h0, 1'b0));
    send_bin(mk_bin(12'd4095, 32'h00030000, 32'h00010000, 32'h0, 32'h0, 1'b1));
    // First bin past the last one falls back to zero.
    apply_window(12'd4094, 12'd10, 12'd5);
    send_bin(mk_bin(12'd5, 32'h00020000, 32'h00010000, 32'h0, 32'h00010000, 1'b0));
    send_bin(mk_bin(12'd6, 32'h00020000, 32'h00010000, 32'h0, 32'h00010000, 1'b1));
    // Last bin past the bin count is clamped to the bin count.
    apply_window(12'd100, 12'd3, 12'd200);
    send_bin(mk_bin(12'd2, 32'h00050000, 32'h00010000, 32'h0, 32'h0, 1'b0));
    send_bin(mk_bin(12'd3, 32'h00050000, 32'h00010000, 32'h0, 32'h0, 1'b0));
    send_bin(mk_bin(12'd100, 32'h00050000, 32'h00010000, 32'h0, 32'h0, 1'b0));
    send_bin(mk_bin(12'd101, 32'h00050000, 32'h00010000, 32'h0, 32'h0, 1'b1));
  endtask

  // Whole histogram pairs swept across random windows, with some truncated
  // pairs and some stray requests in between.
  task automatic test_random_histograms();
    int unsigned      target;
    int unsigned      stop_at;
    logic [IDX_W-1:0] bc, first, last, lo, hi, sweep_lo, sweep_hi;
    logic             drain_pending;
    target        = bins_sent + RANDOM_BINS;
    drain_pending = 1'b1;
    while (bins_sent < target) begin
      case ($urandom_range(9))
        2, 3, 4: begin
          bc    = IDX_W'($urandom_range(1, 24));
          first = IDX_W'($urandom_range(0, bc));
          last  = IDX_W'($urandom_range(first, bc));
        end
        5: begin
          bc    = IDX_W'($urandom_range(1, 24));
          last  = IDX_W'($urandom_range(1, bc));
          first = IDX_W'($urandom_range(last + 1, 4095));
        end
        6: begin
          bc    = IDX_W'($urandom_range(1, 24));
          first = IDX_W'($urandom_range(0, bc));
          last  = IDX_W'($urandom_range(bc + 1, 4095));
        end
        7: begin
          bc    = IDX_W'($urandom_range(4094, 4095));
          first = IDX_W'($urandom_range(4075, 4094));
          last  = $urandom_range(1) ? 12'd0 : 12'd4095;
        end
        8: begin
          bc    = '0;
          first = IDX_W'($urandom_range(0, 4095));
          last  = IDX_W'($urandom_range(0, 4095));
        end
        default: begin
          bc    = IDX_W'($urandom_range(1, 24));
          first = '0;
          last  = '0;
        end
      endcase
      apply_window(bc, first, last);
      no_gaps = ($urandom_range(3) == 0);
      window_bounds(lo, hi);
      sweep_lo = (lo != '0) ? lo - 1'b1 : lo;
      sweep_hi = (hi != '1) ? hi + 1'b1 : hi;
      repeat ($urandom_range(1, 3)) begin
        stop_at = ($urandom_range(7) == 0) ? $urandom_range(sweep_lo, sweep_hi) : sweep_hi;
        for (int unsigned k = sweep_lo; k <= stop_at; k++) begin
          // Now and then hold the sender until every pending sum is out.
          if (drain_pending && k == (sweep_lo + stop_at) / 2) begin
            wait_for_sums();
            drain_pending = 1'b0;
          end
          send_bin(mk_bin(IDX_W'(k), rand_content(), rand_error(), rand_content(),
                          rand_error(), k == stop_at));
        end
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_bin(mk_bin(IDX_W'($urandom_range(0, 4095)), $urandom, $urandom, $urandom,
                          $urandom, $urandom_range(2) == 0));
      end
      if ($urandom_range(7) == 0) drain_pending = 1'b1;
    end
  endtask

  // Receiver stall: short and long stalls, with long stretches of none.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          stall_next = 1'b0;
          stall_hold = $urandom_range(0, 4);
        end
        4, 5: begin
          stall_next = 1'b0;
          stall_hold = $urandom_range(30, 120);
        end
        9: begin
          stall_next = 1'b1;
          stall_hold = $urandom_range(15, 50);
        end
        default: begin
          stall_next = 1'b1;
          stall_hold = $urandom_range(0, 3);
        end
      endcase
    end
    out_stall_i <= stall_next;
  end

  // Each accepted result against the oldest predicted sum.
  always @(posedge clk_i) begin : check_sum
    chi_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        flag_mismatch("unexpected result", '0, chi_square_o);
      end else begin
        want = pending_sums.pop_front();
        if (chi_square_o !== want.chi) flag_mismatch("chi_square", want.chi, chi_square_o);
        if (overflowed_o !== want.ovf) flag_mismatch("overflowed", want.ovf, overflowed_o);
      end
    end
  end

  // Ends the run when no request has moved on any channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_bins();
    test_window_clamp();
    test_random_histograms();
    wait_for_sums();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
